[src/swq_pkg.sv]
// Shared types and constants for the sensor window int8 quantizer.
// Depends on nothing; imported by every module of the block.
package swq_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int CSR_WIDTH    = 16;
   localparam int ROW_OUT_W    = 4;
   localparam int DIFF_W       = SAMPLE_WIDTH + 1;
   localparam int GAIN_W       = 16;
   localparam int PROD_W       = DIFF_W + GAIN_W + 1;
   localparam int RND_SHIFT    = 16;
   localparam int QSUM_W       = PROD_W - RND_SHIFT + 2;

   localparam logic signed [15:0] MEAN_VOLTAGE_RST     = 16'sd860;
   localparam logic signed [15:0] MEAN_CURRENT_RST     = 16'sd843;
   localparam logic signed [15:0] MEAN_TEMPERATURE_RST = 16'sd6180;
   localparam logic [15:0]        GAIN_VOLTAGE_RST     = 16'd13604;
   localparam logic [15:0]        GAIN_CURRENT_RST     = 16'd32004;
   localparam logic [15:0]        GAIN_TEMPERATURE_RST = 16'd3075;
   localparam logic signed [7:0]  ZERO_POINT_RST       = 8'sd62;

   localparam logic signed [7:0]  Q_MIN = -8'sd128;
   localparam logic signed [7:0]  Q_MAX = 8'sd127;

   typedef enum logic [2:0] {
      REG_MEAN_VOLTAGE     = 3'd0,
      REG_MEAN_CURRENT     = 3'd1,
      REG_MEAN_TEMPERATURE = 3'd2,
      REG_GAIN_VOLTAGE     = 3'd3,
      REG_GAIN_CURRENT     = 3'd4,
      REG_GAIN_TEMPERATURE = 3'd5,
      REG_ZERO_POINT       = 3'd6
   } reg_index_type;

   localparam logic [1:0] FEAT_VOLTAGE     = 2'd0;
   localparam logic [1:0] FEAT_CURRENT     = 2'd1;
   localparam logic [1:0] FEAT_TEMPERATURE = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] voltage_sample;
      logic signed [SAMPLE_WIDTH-1:0] current_sample;
      logic signed [SAMPLE_WIDTH-1:0] temperature_sample;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] row_index;
      logic [1:0]           feature_index;
      logic signed [7:0]    quantized_value;
      logic                 last_of_window;
   } rsp_payload_type;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] row_index;
      logic [1:0]           feature_index;
      logic                 last_of_window;
   } tag_type;

endpackage

[src/sensor_window_int8_quantizer.sv]
// Sliding-window int8 quantizer for voltage, current and temperature samples.
// Depends on swq_pkg, swq_cell and swq_quant.
//
// Usage:
//   req_* channel takes one beat of three signed Q8.8 samples. The window is a
//   chain of WINDOW_DEPTH row cells; the new sample enters at the newest end.
//   rsp_* channel then gives 3*WINDOW_DEPTH beats, oldest row first, features
//   in order voltage, current, temperature; last_of_window marks the final one.
//   csr_* writes one of seven registers (means, gains, zero point) per cycle;
//   write only while the block is idle.
// Window walk:
//   Each element passes through the quantizer stage registers; result beats then
//   come one beat a cycle while rsp_stall does not hold them. The chain rotates
//   by one row as each temperature element is issued; req_stall is high until
//   the final element of the window is issued, so no request beat is taken
//   during a walk. A new sample may enter while the last three results are
//   still in the quantizer pipeline.
// Reset:
//   Window cleared to zero, registers at their defaults, pipeline empty.
// Stall:
//   With a beat in the output register, rsp_stall freezes it, the whole
//   quantizer pipeline and the chain rotation; no beat is lost or repeated.
module sensor_window_int8_quantizer
   import swq_pkg::*;
#(
   parameter int WINDOW_DEPTH = 10
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_we,
   input  logic [2:0]      csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   localparam int ROW_W = $clog2(WINDOW_DEPTH);

   logic signed [15:0] mean_voltage_ff, mean_current_ff, mean_temperature_ff;
   logic [15:0]        gain_voltage_ff, gain_current_ff, gain_temperature_ff;
   logic signed [7:0]  zero_point_ff;

   logic             busy_ff, busy_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic [1:0]       feat_cnt_ff, feat_cnt_in;

   logic advance, accept, issue, row_done, last_issue, shift_en;
   req_payload_type rows [WINDOW_DEPTH];
   req_payload_type tail_in;

   logic signed [SAMPLE_WIDTH-1:0] sel_x;
   logic signed [15:0]             sel_mean;
   logic [15:0]                    sel_gain;
   tag_type                        issue_tag;
   logic [ROW_W+ROW_OUT_W-1:0]     row_ext;

   assign accept     = req_valid && !busy_ff;
   assign req_stall  = busy_ff;
   assign issue      = busy_ff && advance;
   assign row_done   = feat_cnt_ff == FEAT_TEMPERATURE;
   assign last_issue = issue && row_done && (row_cnt_ff == ROW_W'(WINDOW_DEPTH - 1));
   assign shift_en   = accept || (issue && row_done);
   assign tail_in    = accept ? req_payload : rows[0];

   // cell chain: every cell takes its newer neighbor; the newest end is fed by
   // the request on load and by the oldest cell while rotating
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      if (i == WINDOW_DEPTH - 1) begin : g_tail
         swq_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .row_in   (tail_in),
            .row_out  (rows[i])
         );
      end else begin : g_body
         swq_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .row_in   (rows[i+1]),
            .row_out  (rows[i])
         );
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      row_cnt_in  = row_cnt_ff;
      feat_cnt_in = feat_cnt_ff;
      if (accept) begin
         busy_in     = 1'b1;
         row_cnt_in  = '0;
         feat_cnt_in = FEAT_VOLTAGE;
      end else if (issue) begin
         if (row_done) begin
            feat_cnt_in = FEAT_VOLTAGE;
            row_cnt_in  = row_cnt_ff + ROW_W'(1);
            if (last_issue) begin
               busy_in = 1'b0;
            end
         end else begin
            feat_cnt_in = feat_cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         row_cnt_ff  <= '0;
         feat_cnt_ff <= FEAT_VOLTAGE;
      end else begin
         busy_ff     <= busy_in;
         row_cnt_ff  <= row_cnt_in;
         feat_cnt_ff <= feat_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_voltage_ff     <= MEAN_VOLTAGE_RST;
         mean_current_ff     <= MEAN_CURRENT_RST;
         mean_temperature_ff <= MEAN_TEMPERATURE_RST;
         gain_voltage_ff     <= GAIN_VOLTAGE_RST;
         gain_current_ff     <= GAIN_CURRENT_RST;
         gain_temperature_ff <= GAIN_TEMPERATURE_RST;
         zero_point_ff       <= ZERO_POINT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_MEAN_VOLTAGE:     mean_voltage_ff     <= $signed(csr_wdata);
            REG_MEAN_CURRENT:     mean_current_ff     <= $signed(csr_wdata);
            REG_MEAN_TEMPERATURE: mean_temperature_ff <= $signed(csr_wdata);
            REG_GAIN_VOLTAGE:     gain_voltage_ff     <= csr_wdata;
            REG_GAIN_CURRENT:     gain_current_ff     <= csr_wdata;
            REG_GAIN_TEMPERATURE: gain_temperature_ff <= csr_wdata;
            REG_ZERO_POINT:       zero_point_ff       <= $signed(csr_wdata[7:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (feat_cnt_ff)
         FEAT_VOLTAGE: begin
            sel_x    = rows[0].voltage_sample;
            sel_mean = mean_voltage_ff;
            sel_gain = gain_voltage_ff;
         end
         FEAT_CURRENT: begin
            sel_x    = rows[0].current_sample;
            sel_mean = mean_current_ff;
            sel_gain = gain_current_ff;
         end
         default: begin
            sel_x    = rows[0].temperature_sample;
            sel_mean = mean_temperature_ff;
            sel_gain = gain_temperature_ff;
         end
      endcase
      row_ext                  = {{ROW_OUT_W{1'b0}}, row_cnt_ff};
      issue_tag.row_index      = row_ext[ROW_OUT_W-1:0];
      issue_tag.feature_index  = feat_cnt_ff;
      issue_tag.last_of_window = last_issue;
   end

   swq_quant u_quant (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (issue),
      .in_x        (sel_x),
      .in_mean     (sel_mean),
      .in_gain     (sel_gain),
      .in_zp       (zero_point_ff),
      .in_tag      (issue_tag),
      .out_valid   (rsp_valid),
      .out_payload (rsp_payload),
      .out_stall   (rsp_stall)
   );

   a_last_is_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_of_window |->
         rsp_payload.feature_index == FEAT_TEMPERATURE)
      else $error("last beat not on temperature feature");

   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=>
         busy_ff && row_cnt_ff == '0 && feat_cnt_ff == FEAT_VOLTAGE)
      else $error("window walk did not start at oldest voltage");

   a_end_walk: assert property (@(posedge clock) disable iff (reset)
      last_issue |=> !busy_ff)
      else $error("busy held after final element issued");

endmodule

[src/swq_cell.sv]
// One window row: three samples that move to the neighbor cell on enable.
// Depends on swq_pkg.
module swq_cell
   import swq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            shift_en,
   input  req_payload_type row_in,
   output req_payload_type row_out
);

   req_payload_type row_ff;
   req_payload_type row_in_mux;

   assign row_in_mux = shift_en ? row_in : row_ff;
   assign row_out    = row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in_mux;
      end
   end

endmodule

[src/swq_quant.sv]
// Three-stage quantizer: subtract mean, multiply by gain, round and saturate.
// Whole pipeline moves when the output register is free. Depends on swq_pkg.
module swq_quant
   import swq_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   output logic                           advance,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] in_x,
   input  logic signed [15:0]             in_mean,
   input  logic [GAIN_W-1:0]              in_gain,
   input  logic signed [7:0]              in_zp,
   input  tag_type                        in_tag,
   output logic                           out_valid,
   output rsp_payload_type                out_payload,
   input  logic                           out_stall
);

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [DIFF_W-1:0] s1_diff_ff;
   logic [GAIN_W-1:0]        s1_gain_ff;
   tag_type                  s1_tag_ff, s2_tag_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;
   rsp_payload_type          s3_payload_ff;

   logic signed [DIFF_W-1:0] diff_in;
   logic signed [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0]        mag;
   logic [PROD_W-1:0]        mag_rnd;
   logic signed [QSUM_W-1:0] r_signed;
   logic signed [QSUM_W-1:0] q_sum;
   logic signed [7:0]        q_sat;
   rsp_payload_type          s3_payload_in;

   assign advance = !s3_valid_ff || !out_stall;

   assign diff_in = DIFF_W'(in_x) - DIFF_W'(in_mean);
   assign prod_in = PROD_W'(s1_diff_ff) * $signed({1'b0, s1_gain_ff});

   always_comb begin
      mag      = s2_prod_ff[PROD_W-1] ? PROD_W'(-s2_prod_ff) : PROD_W'(s2_prod_ff);
      mag_rnd  = mag + PROD_W'(32768);
      r_signed = $signed({2'b00, mag_rnd[PROD_W-1:RND_SHIFT]});
      if (s2_prod_ff[PROD_W-1]) begin
         r_signed = -r_signed;
      end
      q_sum = r_signed + QSUM_W'(in_zp);
      if (q_sum < QSUM_W'(Q_MIN)) begin
         q_sat = Q_MIN;
      end else if (q_sum > QSUM_W'(Q_MAX)) begin
         q_sat = Q_MAX;
      end else begin
         q_sat = q_sum[7:0];
      end
      s3_payload_in.row_index       = s2_tag_ff.row_index;
      s3_payload_in.feature_index   = s2_tag_ff.feature_index;
      s3_payload_in.quantized_value = q_sat;
      s3_payload_in.last_of_window  = s2_tag_ff.last_of_window;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_diff_ff    <= diff_in;
         s1_gain_ff    <= in_gain;
         s1_tag_ff     <= in_tag;
         s2_prod_ff    <= prod_in;
         s2_tag_ff     <= s1_tag_ff;
         s3_payload_ff <= s3_payload_in;
      end
   end

   assign out_valid   = s3_valid_ff;
   assign out_payload = s3_payload_ff;

endmodule

[verif/sensor_window_int8_quantizer_test.sv]
// Self-checking testbench for sensor_window_int8_quantizer: drives sample beats and
// register writes, predicts every quantized window beat, compares each result beat.
// Depends on swq_pkg and the sensor_window_int8_quantizer RTL.
`timescale 1ns / 1ps

module sensor_window_int8_quantizer_test;
   import swq_pkg::*;

   localparam int WINDOW_ROWS = 10;
   localparam int FEATURES = 3;
   localparam int DRAIN_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PRINT_LIMIT = 40;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   // predictor state
   logic signed [15:0] window_rows [WINDOW_ROWS][FEATURES];
   logic signed [15:0] feature_mean [FEATURES];
   logic [15:0] feature_gain [FEATURES];
   logic signed [7:0] zero_point;
   rsp_payload_type pending_beats [$];

   int mismatch_count = 0;
   int beat_count = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit sender_idles = 1'b1;
   bit receiver_stalls = 1'b1;

   sensor_window_int8_quantizer #(.WINDOW_DEPTH(WINDOW_ROWS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [7:0] quantize_feature(logic signed [15:0] x,
         logic signed [15:0] mean, logic [15:0] gain, logic signed [7:0] zp);
      longint diff, prod, mag, rounded, q;
      diff = longint'(x) - longint'(mean);
      prod = diff * longint'(gain);
      mag = (prod < 0) ? -prod : prod;
      rounded = (mag + 64'sd32768) >>> 16;
      if (prod < 0) rounded = -rounded;
      q = rounded + longint'(zp);
      if (q < longint'(Q_MIN)) q = longint'(Q_MIN);
      if (q > longint'(Q_MAX)) q = longint'(Q_MAX);
      return q[7:0];
   endfunction

   task automatic reset_predictor();
      for (int r = 0; r < WINDOW_ROWS; r++)
         for (int f = 0; f < FEATURES; f++)
            window_rows[r][f] = '0;
      feature_mean[FEAT_VOLTAGE] = MEAN_VOLTAGE_RST;
      feature_mean[FEAT_CURRENT] = MEAN_CURRENT_RST;
      feature_mean[FEAT_TEMPERATURE] = MEAN_TEMPERATURE_RST;
      feature_gain[FEAT_VOLTAGE] = GAIN_VOLTAGE_RST;
      feature_gain[FEAT_CURRENT] = GAIN_CURRENT_RST;
      feature_gain[FEAT_TEMPERATURE] = GAIN_TEMPERATURE_RST;
      zero_point = ZERO_POINT_RST;
   endtask

   task automatic push_window_beats(req_payload_type sample);
      rsp_payload_type beat;
      for (int r = 0; r + 1 < WINDOW_ROWS; r++)
         for (int f = 0; f < FEATURES; f++)
            window_rows[r][f] = window_rows[r + 1][f];
      window_rows[WINDOW_ROWS - 1][FEAT_VOLTAGE] = sample.voltage_sample;
      window_rows[WINDOW_ROWS - 1][FEAT_CURRENT] = sample.current_sample;
      window_rows[WINDOW_ROWS - 1][FEAT_TEMPERATURE] = sample.temperature_sample;
      for (int r = 0; r < WINDOW_ROWS; r++) begin
         for (int f = 0; f < FEATURES; f++) begin
            beat.row_index = r[ROW_OUT_W-1:0];
            beat.feature_index = f[1:0];
            beat.quantized_value = quantize_feature(window_rows[r][f], feature_mean[f],
               feature_gain[f], zero_point);
            beat.last_of_window = (r == WINDOW_ROWS - 1) && (f == FEATURES - 1);
            pending_beats.push_back(beat);
         end
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: beat %0d %s: got %0d, expected %0d", $time, beat_count, what, got,
            want);
   endtask

   // result checker
   always @(posedge clock) begin : check_beats
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat, row", rsp_payload.row_index, -1);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_payload.row_index !== want.row_index)
               report_mismatch("row_index", rsp_payload.row_index, want.row_index);
            if (rsp_payload.feature_index !== want.feature_index)
               report_mismatch("feature_index", rsp_payload.feature_index,
                  want.feature_index);
            if (rsp_payload.quantized_value !== want.quantized_value)
               report_mismatch("quantized_value", rsp_payload.quantized_value,
                  want.quantized_value);
            if (rsp_payload.last_of_window !== want.last_of_window)
               report_mismatch("last_of_window", rsp_payload.last_of_window,
                  want.last_of_window);
         end
         beat_count++;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!receiver_stalls) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
         stall_left <= idle_len();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sensor_window_int8_quantizer_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_sample(logic signed [15:0] v, logic signed [15:0] c,
         logic signed [15:0] t);
      req_payload_type sample;
      int unsigned gap;
      sample.voltage_sample = v;
      sample.current_sample = c;
      sample.temperature_sample = t;
      req_valid <= 1'b1;
      req_payload <= sample;
      do @(posedge clock); while (req_stall);
      push_window_beats(sample);
      gap = sender_idles ? idle_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(reg_index_type idx, logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_MEAN_VOLTAGE: feature_mean[FEAT_VOLTAGE] = data;
         REG_MEAN_CURRENT: feature_mean[FEAT_CURRENT] = data;
         REG_MEAN_TEMPERATURE: feature_mean[FEAT_TEMPERATURE] = data;
         REG_GAIN_VOLTAGE: feature_gain[FEAT_VOLTAGE] = data;
         REG_GAIN_CURRENT: feature_gain[FEAT_CURRENT] = data;
         REG_GAIN_TEMPERATURE: feature_gain[FEAT_TEMPERATURE] = data;
         REG_ZERO_POINT: zero_point = data[7:0];
         default: ;
      endcase
   endtask

   // zero point goes out with random upper bits, which must be dropped
   task automatic configure(logic [15:0] mv, logic [15:0] mc, logic [15:0] mt,
         logic [15:0] gv, logic [15:0] gc, logic [15:0] gt, logic [7:0] zp);
      wait_drained();
      set_register(REG_MEAN_VOLTAGE, mv);
      set_register(REG_MEAN_CURRENT, mc);
      set_register(REG_MEAN_TEMPERATURE, mt);
      set_register(REG_GAIN_VOLTAGE, gv);
      set_register(REG_GAIN_CURRENT, gc);
      set_register(REG_GAIN_TEMPERATURE, gt);
      set_register(REG_ZERO_POINT, {8'($urandom), zp});
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_window();
      send_sample(16'sh7fff, -16'sh8000, 16'sh0000);
      send_sample(-16'sh0001, 16'sh0001, -16'sh8000);
      send_sample(16'sh0000, 16'sh7fff, 16'sh7fff);
      send_sample(16'sd860, 16'sd843, 16'sd6180);
   endtask

   task automatic test_rounding_ties();
      // half an LSB per step on voltage: odd differences land exactly on a tie there
      configure(16'h0000, 16'h0000, 16'h0000, 16'd32768, 16'd32767, 16'd32769, 8'h00);
      send_sample(16'sd1, 16'sd1, 16'sd1);
      send_sample(-16'sd1, -16'sd1, -16'sd1);
      send_sample(16'sd3, -16'sd3, 16'sd255);
      send_sample(-16'sd255, 16'sd77, -16'sd77);
   endtask

   task automatic test_zero_gain();
      configure(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000, 16'h0000, 16'h0000,
         Q_MIN);
      send_sample(16'sh7fff, -16'sh8000, 16'sh1234);
      send_sample(-16'sh8000, 16'sh7fff, -16'sh0001);
      configure(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000, 16'h0000, 16'h0000,
         Q_MAX);
      send_sample(16'sh0000, 16'sh0001, -16'sh8000);
   endtask

   task automatic test_saturation();
      configure(16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'hffff, 16'hffff, Q_MAX);
      send_sample(16'sh7fff, -16'sh8000, 16'sh7fff);
      send_sample(-16'sh8000, 16'sh7fff, -16'sh8000);
      configure(16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'h0001, 16'hffff, Q_MIN);
      send_sample(-16'sh8000, 16'sh7fff, 16'sh0000);
      send_sample(16'sh7fff, -16'sh8000, -16'sh0002);
   endtask

   task automatic test_unused_index();
      configure(16'd860, 16'd843, 16'd6180, 16'd13604, 16'd32004, 16'd3075, 8'd62);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_UNUSED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      send_sample(16'sd900, 16'sd800, 16'sd6000);
      send_sample(16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   function automatic logic signed [15:0] pick_sample(logic signed [15:0] center);
      int unsigned r;
      int span;
      r = $urandom_range(0, 9);
      if (r < 4) return 16'($urandom);
      span = (r < 8) ? 300 : 3000;
      return 16'(int'(center) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic test_random_windows();
      int unsigned mode;
      for (int phase = 0; phase < 8; phase++) begin
         mode = $urandom_range(0, 2);
         case (mode)
            0: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 8'($urandom));
            1: configure(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                  16'($urandom_range(0, 8000)), 16'($urandom_range(1000, 40000)),
                  16'($urandom_range(1000, 40000)), 16'($urandom_range(1000, 40000)),
                  8'($urandom));
            default: configure(16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                  16'($urandom_range(0, 600)), 8'($urandom));
         endcase
         sender_idles = (phase % 3) != 0;
         receiver_stalls = (phase % 4) != 1;
         for (int n = 0; n < 46; n++)
            send_sample(pick_sample(feature_mean[FEAT_VOLTAGE]),
               pick_sample(feature_mean[FEAT_CURRENT]),
               pick_sample(feature_mean[FEAT_TEMPERATURE]));
      end
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_window();
      test_rounding_ties();
      test_zero_gain();
      test_saturation();
      test_unused_index();
      test_random_windows();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("sensor_window_int8_quantizer_test passed");
      end else begin
         $display("sensor_window_int8_quantizer_test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/swq_pkg.sv
src/swq_cell.sv
src/swq_quant.sv
src/sensor_window_int8_quantizer.sv
verif/sensor_window_int8_quantizer_test.sv
